>>> hw/rtl/misaligned_load_store_fixup_defines.svh
// ---------------------------------------------------------------------------
// Misaligned load/store fixup: assertion macros
// Shared concurrent assertion forms used by the fixup RTL.
// ---------------------------------------------------------------------------
`ifndef MISALIGNED_LOAD_STORE_FIXUP_DEFINES_SVH
`define MISALIGNED_LOAD_STORE_FIXUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLSF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mlsf_pkg.sv
// ---------------------------------------------------------------------------
// Misaligned load/store fixup package
// Opcode table, flag codes, status codes and payload structs.
// ---------------------------------------------------------------------------
package mlsf_pkg;

  localparam int unsigned OP_LSB   = 10;
  localparam int unsigned OP_W     = 7;
  localparam int unsigned REG_W    = 5;
  localparam int unsigned TGT_LSB  = 5;
  localparam int unsigned BITS_W   = 17;
  localparam int unsigned LEN_W    = 4;

  // Opcode flag bits
  localparam logic [7:0] FL_LD   = 8'h01;
  localparam logic [7:0] FL_ST   = 8'h02;
  localparam logic [7:0] FL_SE   = 8'h04;
  localparam logic [7:0] FL_F    = 8'h08;
  localparam logic [7:0] FL_U    = 8'h10;
  localparam logic [7:0] FL_M    = 8'h20;
  localparam logic [7:0] FL_S    = 8'h40;
  localparam logic [7:0] FL_HARD = 8'h80;

  // Handled operation kinds (flags without the update bit)
  localparam logic [7:0] K_LD    = FL_LD;
  localparam logic [7:0] K_LD_SE = FL_LD | FL_SE;
  localparam logic [7:0] K_LD_SW = FL_LD | FL_S;
  localparam logic [7:0] K_ST    = FL_ST;
  localparam logic [7:0] K_ST_SW = FL_ST | FL_S;
  localparam logic [7:0] K_LD_FP = FL_LD | FL_F;
  localparam logic [7:0] K_ST_FP = FL_ST | FL_F;

  localparam logic [LEN_W-1:0] LEN_HALF = 4'd2;
  localparam logic [LEN_W-1:0] LEN_WORD = 4'd4;
  localparam logic [LEN_W-1:0] LEN_DBL  = 4'd8;
  localparam logic [LEN_W-1:0] LEN_NONE = 4'd0;

  typedef enum logic [1:0] {
    ST_NOT_HANDLED = 2'd0,
    ST_EMULATED    = 2'd1,
    ST_FAULT       = 2'd2
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       flags;
  } op_entry_t;

  typedef struct packed {
    logic [BITS_W-1:0] fault_bits;
    logic [31:0]       fault_address;
    logic [31:0]       source_gpr;
    logic [63:0]       source_fpr;
    logic [63:0]       read_bytes;
    logic              access_fault;
  } fault_item_t;

  typedef struct packed {
    status_t          status;
    logic             gpr_write;
    logic [REG_W-1:0] target_index;
    logic [31:0]      gpr_data;
    logic             fpr_write;
    logic [63:0]      fpr_data;
    logic             mem_write;
    logic [LEN_W-1:0] access_length;
    logic [63:0]      store_bytes;
    logic             update_write;
    logic [REG_W-1:0] update_index;
    logic [31:0]      update_value;
  } fixup_result_t;

  // Fixed opcode table: length and flags per primary opcode slot.
  function automatic op_entry_t op_decode(input logic [OP_W-1:0] op);
    op_entry_t e;
    e = '{len: LEN_NONE, flags: 8'h00};
    case (op)
      7'd0:   e = '{len: LEN_WORD, flags: 8'h01};
      7'd2:   e = '{len: LEN_WORD, flags: 8'h02};
      7'd4:   e = '{len: LEN_HALF, flags: 8'h01};
      7'd5:   e = '{len: LEN_HALF, flags: 8'h05};
      7'd6:   e = '{len: LEN_HALF, flags: 8'h02};
      7'd7:   e = '{len: LEN_WORD, flags: 8'h21};
      7'd8:   e = '{len: LEN_WORD, flags: 8'h49};
      7'd9:   e = '{len: LEN_DBL,  flags: 8'h09};
      7'd10:  e = '{len: LEN_WORD, flags: 8'h4a};
      7'd11:  e = '{len: LEN_DBL,  flags: 8'h0a};
      7'd16:  e = '{len: LEN_WORD, flags: 8'h11};
      7'd18:  e = '{len: LEN_WORD, flags: 8'h12};
      7'd20:  e = '{len: LEN_HALF, flags: 8'h11};
      7'd21:  e = '{len: LEN_HALF, flags: 8'h15};
      7'd22:  e = '{len: LEN_HALF, flags: 8'h12};
      7'd23:  e = '{len: LEN_WORD, flags: 8'h22};
      7'd24:  e = '{len: LEN_WORD, flags: 8'h59};
      7'd25:  e = '{len: LEN_DBL,  flags: 8'h19};
      7'd26:  e = '{len: LEN_WORD, flags: 8'h5a};
      7'd27:  e = '{len: LEN_DBL,  flags: 8'h1a};
      7'd40:  e = '{len: LEN_NONE, flags: 8'h81};
      7'd41:  e = '{len: LEN_NONE, flags: 8'h81};
      7'd42:  e = '{len: LEN_NONE, flags: 8'h82};
      7'd43:  e = '{len: LEN_NONE, flags: 8'h82};
      7'd66:  e = '{len: LEN_NONE, flags: 8'h82};
      7'd72:  e = '{len: LEN_WORD, flags: 8'h41};
      7'd74:  e = '{len: LEN_WORD, flags: 8'h42};
      7'd76:  e = '{len: LEN_HALF, flags: 8'h41};
      7'd78:  e = '{len: LEN_HALF, flags: 8'h42};
      7'd95:  e = '{len: LEN_NONE, flags: 8'h82};
      7'd96:  e = '{len: LEN_WORD, flags: 8'h01};
      7'd98:  e = '{len: LEN_WORD, flags: 8'h02};
      7'd100: e = '{len: LEN_HALF, flags: 8'h01};
      7'd101: e = '{len: LEN_HALF, flags: 8'h05};
      7'd102: e = '{len: LEN_HALF, flags: 8'h02};
      7'd104: e = '{len: LEN_WORD, flags: 8'h49};
      7'd105: e = '{len: LEN_DBL,  flags: 8'h09};
      7'd106: e = '{len: LEN_WORD, flags: 8'h4a};
      7'd107: e = '{len: LEN_DBL,  flags: 8'h0a};
      7'd112: e = '{len: LEN_WORD, flags: 8'h11};
      7'd114: e = '{len: LEN_WORD, flags: 8'h12};
      7'd116: e = '{len: LEN_HALF, flags: 8'h11};
      7'd117: e = '{len: LEN_HALF, flags: 8'h15};
      7'd118: e = '{len: LEN_HALF, flags: 8'h12};
      7'd120: e = '{len: LEN_WORD, flags: 8'h59};
      7'd121: e = '{len: LEN_DBL,  flags: 8'h19};
      7'd122: e = '{len: LEN_WORD, flags: 8'h5a};
      7'd123: e = '{len: LEN_DBL,  flags: 8'h1a};
      default: e = '{len: LEN_NONE, flags: 8'h00};
    endcase
    return e;
  endfunction

endpackage

>>> hw/rtl/mlsf_fault_if.sv
// ---------------------------------------------------------------------------
// Fault channel interface
// Valid/ready channel carrying one alignment fault.
// ---------------------------------------------------------------------------
interface mlsf_fault_if;
  logic        valid;
  logic        ready;
  logic [16:0] fault_bits;
  logic [31:0] fault_address;
  logic [31:0] source_gpr;
  logic [63:0] source_fpr;
  logic [63:0] read_bytes;
  logic        access_fault;

  modport source (
    output valid, fault_bits, fault_address, source_gpr, source_fpr,
           read_bytes, access_fault,
    input  ready
  );

  modport sink (
    input  valid, fault_bits, fault_address, source_gpr, source_fpr,
           read_bytes, access_fault,
    output ready
  );
endinterface

>>> hw/rtl/mlsf_fixup_if.sv
// ---------------------------------------------------------------------------
// Fixup result channel interface
// Valid/ready channel carrying one emulation result.
// ---------------------------------------------------------------------------
interface mlsf_fixup_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        gpr_write;
  logic [4:0]  target_index;
  logic [31:0] gpr_data;
  logic        fpr_write;
  logic [63:0] fpr_data;
  logic        mem_write;
  logic [3:0]  access_length;
  logic [63:0] store_bytes;
  logic        update_write;
  logic [4:0]  update_index;
  logic [31:0] update_value;

  modport source (
    output valid, status, gpr_write, target_index, gpr_data, fpr_write,
           fpr_data, mem_write, access_length, store_bytes, update_write,
           update_index, update_value,
    input  ready
  );

  modport sink (
    input  valid, status, gpr_write, target_index, gpr_data, fpr_write,
           fpr_data, mem_write, access_length, store_bytes, update_write,
           update_index, update_value,
    output ready
  );
endinterface

>>> hw/rtl/misaligned_load_store_fixup.sv
// ---------------------------------------------------------------------------
// Misaligned load/store fixup
// Emulates one misaligned load or store per alignment fault.
// ---------------------------------------------------------------------------
//
//   channel  | modport | carries
//   ---------+---------+---------------------------------------------------
//   fault    | sink    | instruction bits, address, sources, read bytes
//   fixup    | source  | status, register / memory / base-update writes
//
// One transfer per cycle in each direction when neither side stalls.
// Path: fault input register, then result register.
// The core between them is a table lookup plus byte steering.
// rst (synchronous) clears both valid flags; payload registers are not reset.
// A stall on fixup holds the result; fault stays ready while a stage is free.
//
`include "misaligned_load_store_fixup_defines.svh"

module misaligned_load_store_fixup (
  input  logic         clk,
  input  logic         rst,
  mlsf_fault_if.sink   fault,
  mlsf_fixup_if.source fixup
);

  // Input stage
  logic                    in_valid;
  mlsf_pkg::fault_item_t   in_item;
  logic                    in_ready;

  // Result stage
  logic                    res_valid;
  mlsf_pkg::fixup_result_t res;
  logic                    res_ready;

  mlsf_pkg::fixup_result_t res_next;

  // A stage may load when empty or when its content leaves this cycle
  assign res_ready   = !res_valid || fixup.ready;
  assign in_ready    = !in_valid || res_ready;
  assign fault.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= fault.valid;
    end
  end

  // Capture the fault on each transfer
  always_ff @(posedge clk) begin
    if (fault.valid && in_ready) begin
      in_item <= '{fault_bits:    fault.fault_bits,
                   fault_address: fault.fault_address,
                   source_gpr:    fault.source_gpr,
                   source_fpr:    fault.source_fpr,
                   read_bytes:    fault.read_bytes,
                   access_fault:  fault.access_fault};
    end
  end

  mlsf_core u_core (
    .item   (in_item),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= in_valid;
    end
  end

  // Advance the decoded result when the result stage is free
  always_ff @(posedge clk) begin
    if (in_valid && res_ready) begin
      res <= res_next;
    end
  end

  assign fixup.valid         = res_valid;
  assign fixup.status        = res.status;
  assign fixup.gpr_write     = res.gpr_write;
  assign fixup.target_index  = res.target_index;
  assign fixup.gpr_data      = res.gpr_data;
  assign fixup.fpr_write     = res.fpr_write;
  assign fixup.fpr_data      = res.fpr_data;
  assign fixup.mem_write     = res.mem_write;
  assign fixup.access_length = res.access_length;
  assign fixup.store_bytes   = res.store_bytes;
  assign fixup.update_write  = res.update_write;
  assign fixup.update_index  = res.update_index;
  assign fixup.update_value  = res.update_value;

  // A result that is not emulated must carry no write of any kind
  `MLSF_ASSERT_IMPL(a_no_write_unless_emulated, clk, rst,
    res_valid && (res.status != mlsf_pkg::ST_EMULATED),
    !res.gpr_write && !res.fpr_write && !res.mem_write && !res.update_write,
    "write flag set on a result that was not emulated")

  // At most one destination per fault: general register, float register or memory
  `MLSF_ASSERT_IMPL(a_single_destination, clk, rst,
    res_valid, $onehot0({res.gpr_write, res.fpr_write, res.mem_write}),
    "more than one destination written for one fault")

  // Every emulated result writes somewhere
  `MLSF_ASSERT_IMPL(a_emulated_has_write, clk, rst,
    res_valid && (res.status == mlsf_pkg::ST_EMULATED),
    res.gpr_write || res.fpr_write || res.mem_write,
    "emulated result without a register or memory write")

  // A decoded item that may advance shows up on the result side next cycle
  `MLSF_ASSERT_NEXT(a_item_advances, clk, rst,
    in_valid && res_ready, res_valid,
    "decoded fault lost between input and result stage")

endmodule

>>> hw/rtl/mlsf_core.sv
// ---------------------------------------------------------------------------
// Fixup core
// Opcode decode, load extension, byte reversal and store steering.
// ---------------------------------------------------------------------------
module mlsf_core (
  input  mlsf_pkg::fault_item_t   item,
  output mlsf_pkg::fixup_result_t result
);

  logic [mlsf_pkg::OP_W-1:0] op;
  mlsf_pkg::op_entry_t       entry;
  logic [7:0]                kind;
  logic                      handled;
  logic                      is_half;
  logic [31:0]               rd_masked;
  logic [31:0]               rd_swapped;
  logic [31:0]               gpr_masked;
  logic [31:0]               gpr_swapped;

  assign op    = item.fault_bits[mlsf_pkg::OP_LSB +: mlsf_pkg::OP_W];
  assign entry = mlsf_pkg::op_decode(op);
  assign kind  = entry.flags & ~mlsf_pkg::FL_U;

  assign handled = (entry.len != mlsf_pkg::LEN_NONE) &&
                   (kind inside {mlsf_pkg::K_LD, mlsf_pkg::K_LD_SE, mlsf_pkg::K_LD_SW,
                                 mlsf_pkg::K_ST, mlsf_pkg::K_ST_SW, mlsf_pkg::K_LD_FP,
                                 mlsf_pkg::K_ST_FP});

  assign is_half = (entry.len == mlsf_pkg::LEN_HALF);

  // Trim to the operand length, then reverse bytes within that length
  assign rd_masked   = is_half ? {16'h0000, item.read_bytes[15:0]} : item.read_bytes[31:0];
  assign rd_swapped  = is_half ? {16'h0000, item.read_bytes[7:0], item.read_bytes[15:8]}
                               : {item.read_bytes[7:0],   item.read_bytes[15:8],
                                  item.read_bytes[23:16], item.read_bytes[31:24]};
  assign gpr_masked  = is_half ? {16'h0000, item.source_gpr[15:0]} : item.source_gpr;
  assign gpr_swapped = is_half ? {16'h0000, item.source_gpr[7:0], item.source_gpr[15:8]}
                               : {item.source_gpr[7:0],   item.source_gpr[15:8],
                                  item.source_gpr[23:16], item.source_gpr[31:24]};

  always_comb begin
    result               = '0;
    result.status        = mlsf_pkg::ST_NOT_HANDLED;
    result.target_index  = item.fault_bits[mlsf_pkg::TGT_LSB +: mlsf_pkg::REG_W];
    result.access_length = entry.len;
    if (handled && item.access_fault) begin
      result.status = mlsf_pkg::ST_FAULT;
    end else if (handled) begin
      result.status = mlsf_pkg::ST_EMULATED;
      case (kind)
        mlsf_pkg::K_LD_SE: begin
          result.gpr_data  = {{16{item.read_bytes[15]}}, item.read_bytes[15:0]};
          result.gpr_write = 1'b1;
        end
        mlsf_pkg::K_LD: begin
          result.gpr_data  = rd_masked;
          result.gpr_write = 1'b1;
        end
        mlsf_pkg::K_LD_SW: begin
          result.gpr_data  = rd_swapped;
          result.gpr_write = 1'b1;
        end
        mlsf_pkg::K_ST: begin
          result.store_bytes = {32'h0, gpr_masked};
          result.mem_write   = 1'b1;
        end
        mlsf_pkg::K_ST_SW: begin
          result.store_bytes = {32'h0, gpr_swapped};
          result.mem_write   = 1'b1;
        end
        mlsf_pkg::K_LD_FP: begin
          result.fpr_data  = item.read_bytes;
          result.fpr_write = 1'b1;
        end
        mlsf_pkg::K_ST_FP: begin
          result.store_bytes = item.source_fpr;
          result.mem_write   = 1'b1;
        end
        default: begin
          result.mem_write = 1'b0;
        end
      endcase
      if ((entry.flags & mlsf_pkg::FL_U) != 8'h00) begin
        result.update_write = 1'b1;
        result.update_index = item.fault_bits[mlsf_pkg::REG_W-1:0];
        result.update_value = item.fault_address;
      end
    end
  end

endmodule
